FILE: sv/crc8_word_frame_checker_macros.svh
// Assertion macros for the CRC-8 word frame checker.
// No dependencies; included by the modules that carry assertions.
`ifndef CRC8_WORD_FRAME_CHECKER_MACROS_SVH
`define CRC8_WORD_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define CRC8WFC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define CRC8WFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/crc8wfc_pkg.sv
// Shared types, codes and CRC function for the CRC-8 word frame checker.
// No dependencies.
package crc8wfc_pkg;

   localparam int MAX_WORDS = 16;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   localparam logic [4:0] WORD_COUNT_RESET = 5'd6;

   // byte position within a word
   localparam logic [1:0] POS_HIGH  = 2'd0;
   localparam logic [1:0] POS_LOW   = 2'd1;
   localparam logic [1:0] POS_CHECK = 2'd2;
   localparam logic [1:0] POS_BAD   = 2'd3;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_DISCARD  = 2'd2;
   localparam logic [1:0] STATUS_RSVD     = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } beat_type;

   typedef struct packed {
      logic [15:0] data_word;
      logic [1:0]  status;
      logic        last;
   } result_type;

   // one byte through CRC-8, MSB first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // zero counts as one, saturate at MAX_WORDS
   function automatic logic [4:0] eff_count(input logic [4:0] n);
      logic [4:0] r;
      r = n;
      if (n == 5'd0) begin
         r = 5'd1;
      end else if (n > 5'(MAX_WORDS)) begin
         r = 5'(MAX_WORDS);
      end
      return r;
   endfunction

endpackage

FILE: sv/crc8wfc_req_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on nothing.
interface crc8wfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/crc8wfc_rsp_if.sv
// Result channel: valid/ready handshake carrying one checked word.
// Depends on nothing.
interface crc8wfc_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] data_word;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, output data_word, output status, output last,
                   input ready);
   modport sink   (input valid, input data_word, input status, input last,
                   output ready);
endinterface

FILE: sv/crc8wfc_in_stage.sv
// Input register for the CRC-8 word frame checker.
// Depends on crc8wfc_pkg.
module crc8wfc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [7:0]            req_rx_byte,
   output logic                  req_ready,
   output crc8wfc_pkg::beat_type beat,
   input  logic                  beat_take
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign req_ready = !valid_ff || beat_take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (beat_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

FILE: sv/crc8wfc_checker.sv
// Word assembly, CRC-8 check and result register.
// Depends on crc8wfc_pkg and crc8_word_frame_checker_macros.svh.
`include "crc8_word_frame_checker_macros.svh"

module crc8wfc_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  crc8wfc_pkg::beat_type   beat,
   output logic                    beat_take,
   input  logic                    csr_wr_en,
   input  logic [4:0]              csr_wr_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output crc8wfc_pkg::result_type rsp_result
);

   logic [1:0]              pos_ff, pos_in;
   logic [7:0]              high_ff, high_in;
   logic [7:0]              low_ff, low_in;
   logic [7:0]              crc_ff, crc_in;
   logic [4:0]              done_ff, done_in;
   logic                    err_ff, err_in;
   logic [4:0]              count_ff, count_in;
   logic                    rvalid_ff, rvalid_in;
   crc8wfc_pkg::result_type res_ff, res_in;

   logic       out_free;
   logic       is_last;
   logic [5:0] done_next;

   assign out_free  = !rvalid_ff || rsp_ready;
   assign beat_take = beat.valid && ((pos_ff != crc8wfc_pkg::POS_CHECK) || out_free);
   assign done_next = {1'b0, done_ff} + 6'd1;
   assign is_last   = done_next >= {1'b0, crc8wfc_pkg::eff_count(count_ff)};

   always_comb begin
      pos_in    = pos_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      crc_in    = crc_ff;
      done_in   = done_ff;
      err_in    = err_ff;
      res_in    = res_ff;
      count_in  = csr_wr_en ? csr_wr_data : count_ff;
      rvalid_in = rvalid_ff && !rsp_ready;

      if (beat_take) begin
         case (pos_ff)
            crc8wfc_pkg::POS_HIGH: begin
               high_in = beat.rx_byte;
               crc_in  = crc8wfc_pkg::crc8_byte(crc8wfc_pkg::CRC_INIT, beat.rx_byte);
               pos_in  = crc8wfc_pkg::POS_LOW;
            end
            crc8wfc_pkg::POS_LOW: begin
               low_in = beat.rx_byte;
               crc_in = crc8wfc_pkg::crc8_byte(crc_ff, beat.rx_byte);
               pos_in = crc8wfc_pkg::POS_CHECK;
            end
            crc8wfc_pkg::POS_CHECK: begin
               res_in.data_word = {high_ff, low_ff};
               res_in.last      = is_last;
               if (err_ff) begin
                  res_in.status = crc8wfc_pkg::STATUS_DISCARD;
               end else if (crc_ff != beat.rx_byte) begin
                  res_in.status = crc8wfc_pkg::STATUS_MISMATCH;
                  err_in        = 1'b1;
               end else begin
                  res_in.status = crc8wfc_pkg::STATUS_OK;
               end
               if (is_last) begin
                  done_in = 5'd0;
                  err_in  = 1'b0;
               end else begin
                  done_in = done_next[4:0];
               end
               rvalid_in = 1'b1;
               crc_in    = crc8wfc_pkg::CRC_INIT;
               pos_in    = crc8wfc_pkg::POS_HIGH;
            end
            default: begin
               pos_in = crc8wfc_pkg::POS_HIGH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= crc8wfc_pkg::POS_HIGH;
         high_ff   <= 8'h00;
         low_ff    <= 8'h00;
         crc_ff    <= crc8wfc_pkg::CRC_INIT;
         done_ff   <= 5'd0;
         err_ff    <= 1'b0;
         count_ff  <= crc8wfc_pkg::WORD_COUNT_RESET;
         rvalid_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         high_ff   <= high_in;
         low_ff    <= low_in;
         crc_ff    <= crc_in;
         done_ff   <= done_in;
         err_ff    <= err_in;
         count_ff  <= count_in;
         rvalid_ff <= rvalid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid  = rvalid_ff;
   assign rsp_result = res_ff;

   `CRC8WFC_ASSERT_NOW(a_pos_legal, 1'b1, pos_ff != crc8wfc_pkg::POS_BAD, "byte position out of range")
   `CRC8WFC_ASSERT_NOW(a_status_legal, rvalid_ff, res_ff.status != crc8wfc_pkg::STATUS_RSVD, "reserved status on result")
   `CRC8WFC_ASSERT_NEXT(a_check_gives_result, beat_take && pos_ff == crc8wfc_pkg::POS_CHECK, rvalid_ff && pos_ff == crc8wfc_pkg::POS_HIGH, "check byte did not load a result")
   `CRC8WFC_ASSERT_NEXT(a_last_clears, beat_take && pos_ff == crc8wfc_pkg::POS_CHECK && is_last, done_ff == 5'd0 && !err_ff && res_ff.last, "transfer end did not clear state")
   `CRC8WFC_ASSERT_NEXT(a_discard_after_err, beat_take && pos_ff == crc8wfc_pkg::POS_CHECK && err_ff, res_ff.status == crc8wfc_pkg::STATUS_DISCARD, "word after mismatch not discarded")

endmodule

FILE: sv/crc8_word_frame_checker.sv
// CRC-8 word frame checker, top level.
// Depends on crc8wfc_pkg, crc8wfc_req_if, crc8wfc_rsp_if, crc8wfc_in_stage, crc8wfc_checker.
//
// Usage:
//   req_beat carries received bus bytes in order, one per beat. Every three
//   beats form a word: data high byte, data low byte, CRC-8 byte (poly 0x31,
//   init 0xFF, MSB first, no final XOR).
//   rsp_beat gives one beat per word: data_word, status (ok / mismatch /
//   discarded after an earlier mismatch in the transfer) and last.
//   csr_wr_en/csr_wr_data set the words per transfer (0 acts as 1, above 16
//   acts as 16); write only while idle. Reset value is 6.
// Timing:
//   A byte waits in the input register until the checker stage takes it
//   and updates state; the result is valid on rsp_beat in the cycle after
//   the check byte is accepted. Throughput is one byte per cycle while no
//   check byte waits on a result still pending on rsp_beat.
// Reset (synchronous): byte position, CRC, word counter and error flag
//   clear; no result pending.
// Stall: while a result waits on rsp_beat, data bytes keep flowing; a check
//   byte waits in the input register, and req_beat.ready drops only once
//   that register holds a check byte that cannot yet be retired.
module crc8_word_frame_checker (
   input  logic                 clock,
   input  logic                 reset,
   crc8wfc_req_if.sink          req_beat,
   crc8wfc_rsp_if.source        rsp_beat,
   input  logic                 csr_wr_en,
   input  logic [4:0]           csr_wr_data
);

   crc8wfc_pkg::beat_type   beat;
   logic                    beat_take;
   crc8wfc_pkg::result_type result;
   logic                    result_valid;

   crc8wfc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_beat.valid),
      .req_rx_byte (req_beat.rx_byte),
      .req_ready   (req_beat.ready),
      .beat        (beat),
      .beat_take   (beat_take)
   );

   crc8wfc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .beat_take   (beat_take),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (result_valid),
      .rsp_ready   (rsp_beat.ready),
      .rsp_result  (result)
   );

   // result register drives the response beat directly
   assign rsp_beat.valid     = result_valid;
   assign rsp_beat.data_word = result.data_word;
   assign rsp_beat.status    = result.status;
   assign rsp_beat.last      = result.last;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for crc8_word_frame_checker: drives byte beats and checks
// each word result against an in-bench prediction of the CRC-8 word framing.
// Depends on crc8wfc_pkg, crc8wfc_req_if, crc8wfc_rsp_if and the checker RTL.
module tb;

   localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 6;      // covers the two-stage pipe, with margin
   localparam int MAX_REPORTS    = 10;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;

   crc8wfc_req_if req_bus ();
   crc8wfc_rsp_if rsp_bus ();

   crc8_word_frame_checker uut (
      .clock       (clock),
      .reset       (reset),
      .req_beat    (req_bus),
      .rsp_beat    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared state between the sender, the result sink and the tests
   // ---------------------------------------------------------------------
   crc8wfc_pkg::result_type pending_words[$];   // expected results, oldest first
   int         mismatches;
   int         src_idle_pct;       // chance per beat that the sender holds off
   int         rcv_idle_pct;       // chance per cycle that the sink drops ready
   int         stall_req;          // long sink hold-off, handed to the sink
   int         quiet_cycles;
   int         bytes_sent;
   int         seg_idx;

   // Frame tracker: mirrors what the block should hold between beats
   logic [1:0] trk_pos;
   logic [7:0] trk_high;
   logic [7:0] trk_low;
   logic [7:0] trk_crc;
   logic [4:0] trk_done;
   logic       trk_error;
   logic [4:0] trk_count;          // word_count register as last written

   // CRC-8, poly 0x31, MSB first; used both to predict and to build words
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      r = crc ^ d;
      repeat (8) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ crc8wfc_pkg::CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
      return crc8_step(crc8_step(crc8wfc_pkg::CRC_INIT, hi), lo);
   endfunction

   // Advance the frame tracker by one accepted byte; queue a result on
   // the check byte.
   task automatic track_byte(input logic [7:0] b);
      int                      limit;
      crc8wfc_pkg::result_type r;
      if (trk_pos == crc8wfc_pkg::POS_HIGH) begin
         trk_high = b;
         trk_crc  = crc8_step(crc8wfc_pkg::CRC_INIT, b);
         trk_pos  = crc8wfc_pkg::POS_LOW;
      end else if (trk_pos == crc8wfc_pkg::POS_LOW) begin
         trk_low = b;
         trk_crc = crc8_step(trk_crc, b);
         trk_pos = crc8wfc_pkg::POS_CHECK;
      end else begin
         if (trk_error) begin
            r.status = crc8wfc_pkg::STATUS_DISCARD;
         end else if (trk_crc != b) begin
            r.status  = crc8wfc_pkg::STATUS_MISMATCH;
            trk_error = 1'b1;
         end else begin
            r.status = crc8wfc_pkg::STATUS_OK;
         end
         // zero acts as one, anything over the max saturates
         limit = int'(trk_count);
         if (limit == 0) limit = 1;
         if (limit > crc8wfc_pkg::MAX_WORDS) limit = crc8wfc_pkg::MAX_WORDS;
         r.last      = (int'(trk_done) + 1) >= limit;
         r.data_word = {trk_high, trk_low};
         if (r.last) begin
            trk_done  = '0;
            trk_error = 1'b0;
         end else begin
            trk_done = trk_done + 5'd1;
         end
         trk_pos = crc8wfc_pkg::POS_HIGH;
         trk_crc = crc8wfc_pkg::CRC_INIT;
         pending_words.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender. valid is left high after an accepted beat; the next call
   // either keeps it up with new data or drops it, never both in one step.
   // Anything that waits on time must drop valid first.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      track_byte(b);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [7:0] hi, input logic [7:0] lo, input bit corrupt);
      logic [7:0] chk;
      chk = word_crc(hi, lo);
      if (corrupt) chk = chk ^ 8'($urandom_range(1, 255));
      send_byte(hi);
      send_byte(lo);
      send_byte(chk);
   endtask

   // Stop sending and wait until every expected word is back
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   // Register write only with the block idle; data bytes leave no
   // result to wait on, so let the pipe settle as well.
   task automatic write_word_count(input logic [4:0] n);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trk_count = n;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result sink: drives ready, checks each accepted beat in order
   // ---------------------------------------------------------------------
   task automatic log_failure(input string what, input crc8wfc_pkg::result_type want,
                              input crc8wfc_pkg::result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t %s: expected word=%h status=%0d last=%0d, got word=%h status=%0d last=%0d",
                  $realtime, what, want.data_word, want.status, want.last,
                  got.data_word, got.status, got.last);
      end
   endtask

   initial begin : result_sink
      crc8wfc_pkg::result_type got;
      crc8wfc_pkg::result_type want;
      int                      stall_cnt;
      stall_cnt     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.data_word, rsp_bus.status, rsp_bus.last};
            if (pending_words.size() == 0) begin
               log_failure("unexpected result beat", '0, got);
            end else begin
               want = pending_words.pop_front();
               if (got !== want) log_failure("result mismatch", want, got);
            end
         end
         // long hold-off is counted here, one cycle per edge
         if (stall_req > 0) begin
            stall_cnt = stall_req;
            stall_req = 0;
         end
         if (stall_cnt > 0) begin
            stall_cnt--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Watchdog: too long with no beat on either side ends the run
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Count left at its reset value of six. Covers all-zero and all-one
   // bytes, a good word, a first mismatch, discards after it (one with a
   // bad CRC of its own, which must still read as discarded) and the
   // last flag on the sixth word.
   task automatic test_reset_count();
      send_word(8'h00, 8'h00, 1'b0);
      send_word(8'hFF, 8'hFF, 1'b1);
      send_word(8'h12, 8'h34, 1'b1);
      send_word(8'hAB, 8'hCD, 1'b0);
      send_word(8'h80, 8'h01, 1'b0);
      send_word(8'h7F, 8'hFE, 1'b0);
   endtask

   // Zero words per transfer behaves as one: every word is last, and the
   // error flag from the previous transfer must be gone.
   task automatic test_zero_count();
      write_word_count(5'd0);
      send_word(8'h5A, 8'hA5, 1'b0);
   endtask

   // New count lands mid-transfer: one word of a three-word transfer,
   // pause until it is back, then drop the count to one. The next word has
   // already passed the new count, so it must come out last.
   task automatic test_count_change();
      write_word_count(5'd3);
      send_word(8'hC3, 8'h3C, 1'b0);
      write_word_count(5'd1);
      send_word(8'h01, 8'h80, 1'b1);
   endtask

   // Sink holds off for a long stretch while the sender keeps offering,
   // so the block backs up and drops req ready.
   task automatic test_backpressure();
      int i;
      write_word_count(5'd4);
      stall_req = 64;
      for (i = 0; i < 15; i++) send_word(pick_byte(), pick_byte(), $urandom_range(99) < 20);
      drain_results();
   endtask

   // Random segments, each under a freshly written count. Mostly well
   // formed words with random data and some bad CRCs; a few stray bytes
   // knock the framing off.
   task automatic test_random_frames(input int src_pct, input int rcv_pct);
      logic [4:0] extremes[4];
      logic [4:0] n;
      int         seg;
      int         stop_at;
      extremes = '{5'd31, 5'd16, 5'd1, 5'd0};
      for (seg = 0; seg < 4; seg++) begin
         n = (seg_idx < 4) ? extremes[seg_idx] : 5'($urandom_range(31));
         seg_idx++;
         write_word_count(n);
         src_idle_pct = src_pct;
         rcv_idle_pct = rcv_pct;
         stop_at = bytes_sent + 44;
         while (bytes_sent < stop_at) begin
            if ($urandom_range(99) < 4) begin
               send_byte(8'($urandom));
            end else begin
               send_word(pick_byte(), pick_byte(), $urandom_range(99) < 12);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      mismatches      = 0;
      stall_req       = 0;
      quiet_cycles    = 0;
      bytes_sent      = 0;
      seg_idx         = 0;
      src_idle_pct    = 29;
      rcv_idle_pct    = 78;
      trk_pos         = crc8wfc_pkg::POS_HIGH;
      trk_high        = '0;
      trk_low         = '0;
      trk_crc         = crc8wfc_pkg::CRC_INIT;
      trk_done        = '0;
      trk_error       = 1'b0;
      trk_count       = crc8wfc_pkg::WORD_COUNT_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_count();
      test_zero_count();
      test_count_change();
      test_backpressure();
      test_random_frames(29, 78);
      test_random_frames(78, 29);
      test_random_frames(0, 0);

      // all sent; wait for the tail and watch for strays
      drain_results();
      rcv_idle_pct = 0;
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: crc8_word_frame_checker.f
+incdir+sv
sv/crc8wfc_pkg.sv
sv/crc8wfc_req_if.sv
sv/crc8wfc_rsp_if.sv
sv/crc8wfc_in_stage.sv
sv/crc8wfc_checker.sv
sv/crc8_word_frame_checker.sv
dv/tb.sv
